### design/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Clocked on clk, quiet while arst_n is low.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define MLFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MLFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/mlfd_pkg.sv
// -----------------------------------------------------------------------------
// mlfd_pkg
// Shared types and constants of the length-prefixed frame deframer.
// -----------------------------------------------------------------------------
`default_nettype none

package mlfd_pkg;

	localparam logic [7:0] MagicFirst  = 8'h4D; // 'M'
	localparam logic [7:0] MagicSecond = 8'h53; // 'S'

	localparam int LenW    = 16;
	localparam int CfgIdxW = 2;

	localparam logic [CfgIdxW-1:0] CfgMinLen = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] CfgMaxLen = CfgIdxW'(1);

	localparam logic [LenW-1:0] MinLenReset = LenW'(2);
	localparam logic [LenW-1:0] MaxLenReset = LenW'(65535);

	// result queue between front and back
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	typedef enum logic [1:0] {
		ST_PAYLOAD   = 2'd0,
		ST_BAD_MAGIC = 2'd1,
		ST_TOO_SHORT = 2'd2,
		ST_TOO_LONG  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		status_t    status;
	} result_t;

endpackage

`default_nettype wire

### design/mlfd_if.sv
// -----------------------------------------------------------------------------
// mlfd_if
// Channel interfaces: received bytes, frame results and register writes.
// -----------------------------------------------------------------------------
`default_nettype none

interface mlfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface mlfd_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       first_of_frame;
	logic       last_of_frame;
	logic [1:0] status;

	modport source (output valid, output out_byte, output first_of_frame,
		output last_of_frame, output status, input ready);
	modport sink (input valid, input out_byte, input first_of_frame,
		input last_of_frame, input status, output ready);
endinterface

interface mlfd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mlfd_pkg::CfgIdxW-1:0]    index;
	logic [mlfd_pkg::LenW-1:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### design/mlfd_front.sv
// -----------------------------------------------------------------------------
// mlfd_front
// Header parser: checks magic and length, counts payload, classifies each byte.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mlfd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	mlfd_rx_if.sink                rx,
	mlfd_cfg_if.sink               cfg,
	input  wire logic              push_ready,
	output logic                   push_valid,
	output mlfd_pkg::result_t      push_data
);

	typedef enum logic [1:0] {
		HDR_MAGIC0 = 2'd0,
		HDR_MAGIC1 = 2'd1,
		HDR_LEN_HI = 2'd2,
		HDR_LEN_LO = 2'd3
	} hdr_state_t;

	hdr_state_t                  hdr_q, hdr_d;
	logic                        in_payload_q, in_payload_d;
	logic                        magic_ok_q, magic_ok_d;
	logic [7:0]                  len_hi_q, len_hi_d;
	logic [mlfd_pkg::LenW-1:0]   left_q, left_d;
	logic                        first_pend_q, first_pend_d;
	logic [mlfd_pkg::LenW-1:0]   min_len_q, max_len_q;
	logic [mlfd_pkg::LenW-1:0]   frame_len;
	logic                        res_valid;
	mlfd_pkg::result_t           res;
	logic                        accept;

	assign rx.ready   = push_ready;
	assign cfg.ready  = 1'b1;
	assign accept     = rx.valid && rx.ready;
	assign frame_len  = {len_hi_q, rx.in_byte};
	assign push_valid = accept && res_valid;
	assign push_data  = res;

	always_comb begin
		hdr_d        = hdr_q;
		in_payload_d = in_payload_q;
		magic_ok_d   = magic_ok_q;
		len_hi_d     = len_hi_q;
		left_d       = left_q;
		first_pend_d = first_pend_q;
		res_valid    = 1'b0;
		res          = '{data: rx.in_byte, first: first_pend_q,
			last: (left_q <= mlfd_pkg::LenW'(1)), status: mlfd_pkg::ST_PAYLOAD};
		if (in_payload_q) begin
			res_valid    = 1'b1;
			first_pend_d = 1'b0;
			if (res.last) begin
				// frame done: back to hunting
				left_d       = '0;
				in_payload_d = 1'b0;
				hdr_d        = HDR_MAGIC0;
				magic_ok_d   = 1'b1;
				len_hi_d     = '0;
			end else begin
				left_d = left_q - mlfd_pkg::LenW'(1);
			end
		end else begin
			case (hdr_q)
				HDR_MAGIC0: begin
					magic_ok_d = (rx.in_byte == mlfd_pkg::MagicFirst);
					hdr_d      = HDR_MAGIC1;
				end
				HDR_MAGIC1: begin
					magic_ok_d = magic_ok_q && (rx.in_byte == mlfd_pkg::MagicSecond);
					hdr_d      = HDR_LEN_HI;
				end
				HDR_LEN_HI: begin
					len_hi_d = rx.in_byte;
					hdr_d    = HDR_LEN_LO;
				end
				HDR_LEN_LO: begin
					hdr_d      = HDR_MAGIC0;
					magic_ok_d = 1'b1;
					len_hi_d   = '0;
					res.data   = '0;
					res.first  = 1'b0;
					res.last   = 1'b0;
					// bad magic first, then too short, then too long
					if (!magic_ok_q) begin
						res_valid  = 1'b1;
						res.status = mlfd_pkg::ST_BAD_MAGIC;
					end else if (frame_len < min_len_q) begin
						res_valid  = 1'b1;
						res.status = mlfd_pkg::ST_TOO_SHORT;
					end else if (frame_len > max_len_q) begin
						res_valid  = 1'b1;
						res.status = mlfd_pkg::ST_TOO_LONG;
					end else if (frame_len != '0) begin
						in_payload_d = 1'b1;
						left_d       = frame_len;
						first_pend_d = 1'b1;
					end
				end
				default: begin
					hdr_d = HDR_MAGIC0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q        <= HDR_MAGIC0;
			in_payload_q <= 1'b0;
			magic_ok_q   <= 1'b1;
			len_hi_q     <= '0;
			left_q       <= '0;
			first_pend_q <= 1'b0;
			min_len_q    <= mlfd_pkg::MinLenReset;
			max_len_q    <= mlfd_pkg::MaxLenReset;
		end else begin
			if (accept) begin
				hdr_q        <= hdr_d;
				in_payload_q <= in_payload_d;
				magic_ok_q   <= magic_ok_d;
				len_hi_q     <= len_hi_d;
				left_q       <= left_d;
				first_pend_q <= first_pend_d;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					mlfd_pkg::CfgMinLen: min_len_q <= cfg.data;
					mlfd_pkg::CfgMaxLen: max_len_q <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	`MLFD_ASSERT_NOW(a_payload_count, in_payload_q, left_q != '0, "payload with no bytes left")
	`MLFD_ASSERT_NOW(a_hunt_idle, in_payload_q, hdr_q == HDR_MAGIC0, "payload mid header")
	`MLFD_ASSERT_NEXT(a_first_once, accept && in_payload_q, !first_pend_q, "first mark repeated")

endmodule

`default_nettype wire

### design/mlfd_queue.sv
// -----------------------------------------------------------------------------
// mlfd_queue
// Small result queue between the parser and the output stage.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mlfd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	input  wire mlfd_pkg::result_t push_data,
	output logic                   push_ready,
	input  wire logic              pop,
	output logic                   not_empty,
	output mlfd_pkg::result_t      head
);

	mlfd_pkg::result_t               entry_q [mlfd_pkg::QDepth];
	logic [mlfd_pkg::QPtrW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [mlfd_pkg::QCntW-1:0]      count_q;
	logic                            do_push, do_pop;

	assign push_ready = (count_q != mlfd_pkg::QCntW'(mlfd_pkg::QDepth));
	assign not_empty  = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + mlfd_pkg::QPtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + mlfd_pkg::QPtrW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + mlfd_pkg::QCntW'(1);
				2'b01:   count_q <= count_q - mlfd_pkg::QCntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`MLFD_ASSERT_NOW(a_no_overflow, push_valid, push_ready, "push into full queue")
	`MLFD_ASSERT_NOW(a_ptr_gap, 1'b1, count_q[mlfd_pkg::QPtrW-1:0] == mlfd_pkg::QPtrW'(wr_ptr_q - rd_ptr_q), "pointer and count disagree")

endmodule

`default_nettype wire

### design/mlfd_back.sv
// -----------------------------------------------------------------------------
// mlfd_back
// Output stage: draws results from the queue into the frame channel register.
// -----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module mlfd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              not_empty,
	input  wire mlfd_pkg::result_t head,
	output logic                   pop,
	mlfd_frame_if.source           frame
);

	logic              out_valid_q;
	mlfd_pkg::result_t out_q;

	// refill whenever the register is empty or its request is being taken
	assign pop = not_empty && (!out_valid_q || frame.ready);

	assign frame.valid          = out_valid_q;
	assign frame.out_byte       = out_q.data;
	assign frame.first_of_frame = out_q.first;
	assign frame.last_of_frame  = out_q.last;
	assign frame.status         = out_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (frame.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= head;
		end
	end

	`MLFD_ASSERT_NOW(a_error_clean, out_valid_q && (out_q.status != mlfd_pkg::ST_PAYLOAD), (out_q.data == '0) && !out_q.first && !out_q.last, "error result carries payload marks")

endmodule

`default_nettype wire

### design/magic_length_frame_deframer.sv
// -----------------------------------------------------------------------------
// magic_length_frame_deframer
// Splits an 'M' 'S' length-prefixed byte stream into marked payload bytes and error results.
// -----------------------------------------------------------------------------
//  channel  dir   carries
//  rx       sink  in_byte, one stream byte per request
//  frame    src   out_byte, first_of_frame, last_of_frame, status
//  cfg      sink  index, data (0: min_payload_len, 1: max_payload_len)
//
//  One byte per cycle sustained while the result queue has room; a result passes
//  through the result queue and the output register before it is offered.
//  Rate is set by the header parser, which decides on each byte as it is taken; cfg is always ready.
//  Reset clears the parser and sets the limits to 2 and 65535, no clear pass.
//  A stalled frame fills a four-entry result queue, then rx.ready drops.
// -----------------------------------------------------------------------------
`default_nettype none

module magic_length_frame_deframer (
	input  wire logic    clk,
	input  wire logic    arst_n,
	mlfd_rx_if.sink      rx,
	mlfd_frame_if.source frame,
	mlfd_cfg_if.sink     cfg
);

	logic              push_valid, push_ready;
	mlfd_pkg::result_t push_data;
	logic              pop, not_empty;
	mlfd_pkg::result_t head;

	mlfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.cfg        (cfg),
		.push_ready (push_ready),
		.push_valid (push_valid),
		.push_data  (push_data)
	);

	mlfd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.not_empty  (not_empty),
		.head       (head)
	);

	mlfd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.frame     (frame)
	);

endmodule

`default_nettype wire
